// File: design/cles_pkg.sv
// Shared types, constants and constant-scaling functions for the CCT light effect sequencer.
package cles_pkg;

	localparam int TEMP_W  = 14;
	localparam int LIGHT_W = 7;
	localparam int CMP_W   = 10;
	localparam int MCAND_W = 24;
	localparam int PROD_W  = 31;
	localparam int DEN_W   = 21;
	localparam int QUO_W   = 11;

	localparam logic [CMP_W-1:0]   CMP_MAX      = 10'd550;
	localparam logic [QUO_W-1:0]   CMP_MAX_Q    = 11'd550;
	localparam logic [QUO_W-1:0]   CMP_MIN_Q    = 11'd20;
	localparam logic [LIGHT_W-1:0] PCT_FULL     = 7'd100;
	localparam logic [4:0]         STEP_LAST    = 5'd29;
	localparam logic [8:0]         BLINK_LAST   = 9'd399;
	localparam logic [8:0]         BLINK_ON     = 9'd200;
	localparam logic [8:0]         BLINK_OFF    = 9'd0;
	localparam logic [TEMP_W:0]    SWEEP_STEP   = 15'd50;

	localparam logic [1:0] MODE_NONE    = 2'd0;
	localparam logic [1:0] MODE_BREATHE = 2'd1;
	localparam logic [1:0] MODE_BLINK   = 2'd2;
	localparam logic [1:0] MODE_SWEEP   = 2'd3;

	localparam logic CFG_WARM = 1'b0;
	localparam logic CFG_COLD = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic               active;
		logic [1:0]         sub_mode;
		logic [TEMP_W-1:0]  temperature;
		logic [LIGHT_W-1:0] lightness;
	} in_item_t;

	typedef struct packed {
		logic [CMP_W-1:0] warm_compare;
		logic [CMP_W-1:0] cold_compare;
		logic             changed;
	} out_item_t;

	typedef struct packed {
		logic               start;
		logic [MCAND_W-1:0] mcand;
		logic [LIGHT_W-1:0] light;
		logic [DEN_W-1:0]   den;
	} lane_req_t;

	typedef struct packed {
		logic             busy;
		logic [CMP_W-1:0] cmp;
	} lane_rsp_t;

	function automatic logic [MCAND_W-1:0] scale_warm(input logic [TEMP_W-1:0] d);
		return {10'd0, d} * 24'd530;
	endfunction

	function automatic logic [MCAND_W-1:0] scale_cold(input logic [TEMP_W-1:0] d);
		return {10'd0, d} * 24'd1000;
	endfunction

	function automatic logic [DEN_W-1:0] scale_den(input logic [TEMP_W-1:0] d);
		return {7'd0, d} * 21'd100;
	endfunction

endpackage

// File: design/cct_light_effect_sequencer_unit.sv
// Top level of the CCT light effect sequencer: effect state, job sequencing and output register.
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries set-colour commands and 1 ms ticks.
//   Output channel (out_valid / out_stall / out_data) returns one result per request: the
//   warm and cold compare values after the request and a flag set when they were rewritten.
//   Configuration (cfg_we / cfg_index / cfg_data) writes the warm bound (index 0) and the cold
//   bound (index 1); write only while the block is idle.
// Sequence: a request that does not recompute the compares goes straight to the output load;
//   a recompute with an empty span runs clamp, operand load with zeroing, output load. Otherwise
//   a recompute runs clamp, operand load, a multiply step per brightness bit and a divide step
//   per quotient bit in two lanes that run side by side, lane pick-up, output load.
// Throughput: one request at a time; the next request is taken the cycle after the current
//   result has been loaded into the output register.
// Reset: compares 0, brightness ramp at 100 going down, saved brightness 50, warm bound 2700,
//   cold bound 6500, no result pending.
// Stall: a result waits in the output register while out_stall is high; the next request may
//   be accepted and worked on meanwhile, and its result is held until the register frees.
module cct_light_effect_sequencer_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  cles_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output cles_pkg::out_item_t            out_data,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [cles_pkg::TEMP_W-1:0]    cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CLAMP = 5'b00010,
		S_LOAD  = 5'b00100,
		S_CALC  = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t                         state_q;
	logic [cles_pkg::TEMP_W-1:0]    warm_bound_q;
	logic [cles_pkg::TEMP_W-1:0]    cold_bound_q;
	logic [cles_pkg::CMP_W-1:0]     warm_reg_q;
	logic [cles_pkg::CMP_W-1:0]     cold_reg_q;
	logic [4:0]                     ph30_q;
	logic [8:0]                     ph400_q;
	logic [cles_pkg::LIGHT_W-1:0]   fade_q;
	logic                           going_up_q;
	logic [1:0]                     prev_mode_q;
	logic [cles_pkg::TEMP_W-1:0]    effect_temp_q;
	logic [cles_pkg::TEMP_W-1:0]    sweep_temp_q;
	logic [cles_pkg::LIGHT_W-1:0]   effect_light_q;
	logic [cles_pkg::TEMP_W-1:0]    saved_temp_q;
	logic [cles_pkg::LIGHT_W-1:0]   saved_light_q;
	logic [cles_pkg::TEMP_W-1:0]    job_t_q;
	logic [cles_pkg::LIGHT_W-1:0]   job_l_q;
	logic                           job_set_q;
	logic                           job_chg_q;
	logic [cles_pkg::TEMP_W-1:0]    tc_q;
	logic                           out_valid_q;
	cles_pkg::out_item_t            out_data_q;

	logic                           in_acc;
	logic                           out_free;
	logic [4:0]                     ph30_inc;
	logic [8:0]                     ph400_inc;
	logic                           mode_chg;
	logic [cles_pkg::TEMP_W-1:0]    et;
	logic [cles_pkg::TEMP_W-1:0]    st;
	logic [cles_pkg::LIGHT_W-1:0]   el;
	logic                           step30;
	logic [cles_pkg::LIGHT_W-1:0]   fade_nx;
	logic                           up_fade_nx;
	logic [cles_pkg::TEMP_W:0]      s_dn;
	logic [cles_pkg::TEMP_W:0]      s_up;
	logic [cles_pkg::TEMP_W-1:0]    sweep_nx;
	logic                           up_sweep_nx;
	logic                           recalc;
	logic                           chg_now;
	logic [cles_pkg::TEMP_W-1:0]    tc;
	logic                           span_empty;
	cles_pkg::lane_req_t            warm_req;
	cles_pkg::lane_req_t            cold_req;
	cles_pkg::lane_rsp_t            warm_rsp;
	cles_pkg::lane_rsp_t            cold_rsp;

	assign in_acc   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign ph30_inc  = (ph30_q == cles_pkg::STEP_LAST) ? 5'd0 : ph30_q + 5'd1;
	assign ph400_inc = (ph400_q == cles_pkg::BLINK_LAST) ? 9'd0 : ph400_q + 9'd1;
	assign step30    = (ph30_inc == 5'd0);

	assign mode_chg = (prev_mode_q != in_data.sub_mode);
	assign et       = mode_chg ? saved_temp_q  : effect_temp_q;
	assign st       = mode_chg ? saved_temp_q  : sweep_temp_q;
	assign el       = mode_chg ? saved_light_q : effect_light_q;

	// breathing ramp: turn at 0 and at full
	always_comb begin
		if (!going_up_q) begin
			if (fade_q <= 7'd1) begin
				fade_nx    = '0;
				up_fade_nx = 1'b1;
			end else begin
				fade_nx    = fade_q - 7'd1;
				up_fade_nx = 1'b0;
			end
		end else begin
			if (({1'b0, fade_q} + 8'd1) >= {1'b0, cles_pkg::PCT_FULL}) begin
				fade_nx    = cles_pkg::PCT_FULL;
				up_fade_nx = 1'b0;
			end else begin
				fade_nx    = fade_q + 7'd1;
				up_fade_nx = 1'b1;
			end
		end
	end

	assign s_dn = {1'b0, st} - cles_pkg::SWEEP_STEP;
	assign s_up = {1'b0, st} + cles_pkg::SWEEP_STEP;

	// temperature sweep: stop at the bounds and turn
	always_comb begin
		if (!going_up_q) begin
			if ($signed(s_dn) <= $signed({1'b0, warm_bound_q})) begin
				sweep_nx    = warm_bound_q;
				up_sweep_nx = 1'b1;
			end else begin
				sweep_nx    = s_dn[cles_pkg::TEMP_W-1:0];
				up_sweep_nx = 1'b0;
			end
		end else begin
			if (s_up >= {1'b0, cold_bound_q}) begin
				sweep_nx    = cold_bound_q;
				up_sweep_nx = 1'b0;
			end else begin
				sweep_nx    = s_up[cles_pkg::TEMP_W-1:0];
				up_sweep_nx = 1'b1;
			end
		end
	end

	// decide whether the request recomputes and whether it rewrites the compares
	always_comb begin
		recalc  = 1'b0;
		chg_now = 1'b0;
		if (in_data.cmd) begin
			recalc  = 1'b1;
			chg_now = 1'b1;
		end else if (in_data.active) begin
			unique case (in_data.sub_mode)
				cles_pkg::MODE_BREATHE: begin
					recalc  = step30;
					chg_now = step30;
				end
				cles_pkg::MODE_BLINK: begin
					recalc  = (ph400_inc == cles_pkg::BLINK_ON);
					chg_now = (ph400_inc == cles_pkg::BLINK_ON) ||
						(ph400_inc == cles_pkg::BLINK_OFF);
				end
				cles_pkg::MODE_SWEEP: begin
					recalc  = step30;
					chg_now = step30;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		if (job_t_q < warm_bound_q) begin
			tc = warm_bound_q;
		end else if (job_t_q > cold_bound_q) begin
			tc = cold_bound_q;
		end else begin
			tc = job_t_q;
		end
		if (tc > cold_bound_q) begin
			tc = cold_bound_q;
		end
	end

	assign span_empty = (cold_bound_q <= warm_bound_q);

	assign warm_req.start = (state_q == S_LOAD) && !span_empty;
	assign warm_req.mcand = cles_pkg::scale_warm(cold_bound_q - tc_q);
	assign warm_req.light = job_l_q;
	assign warm_req.den   = cles_pkg::scale_den(cold_bound_q - warm_bound_q);

	assign cold_req.start = (state_q == S_LOAD) && !span_empty;
	assign cold_req.mcand = cles_pkg::scale_cold(tc_q - warm_bound_q);
	assign cold_req.light = job_l_q;
	assign cold_req.den   = cles_pkg::scale_den(cold_bound_q - warm_bound_q);

	cles_lane u_warm_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (warm_req),
		.rsp    (warm_rsp)
	);

	cles_lane u_cold_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cold_req),
		.rsp    (cold_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_bound_q <= 14'd2700;
			cold_bound_q <= 14'd6500;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cles_pkg::CFG_WARM: warm_bound_q <= cfg_data;
				cles_pkg::CFG_COLD: cold_bound_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			warm_reg_q     <= '0;
			cold_reg_q     <= '0;
			ph30_q         <= '0;
			ph400_q        <= '0;
			fade_q         <= cles_pkg::PCT_FULL;
			going_up_q     <= 1'b0;
			prev_mode_q    <= cles_pkg::MODE_NONE;
			effect_temp_q  <= '0;
			sweep_temp_q   <= '0;
			effect_light_q <= '0;
			saved_temp_q   <= '0;
			saved_light_q  <= 7'd50;
			job_t_q        <= '0;
			job_l_q        <= '0;
			job_set_q      <= 1'b0;
			job_chg_q      <= 1'b0;
			tc_q           <= '0;
			out_data_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						job_set_q <= in_data.cmd;
						job_chg_q <= chg_now;
						state_q   <= recalc ? S_CLAMP : S_OUT;
						if (in_data.cmd) begin
							job_t_q <= in_data.temperature;
							job_l_q <= in_data.lightness;
						end else if (in_data.active) begin
							ph30_q         <= ph30_inc;
							ph400_q        <= ph400_inc;
							prev_mode_q    <= in_data.sub_mode;
							effect_temp_q  <= et;
							sweep_temp_q   <= ((in_data.sub_mode == cles_pkg::MODE_SWEEP) &&
								step30) ? sweep_nx : st;
							effect_light_q <= el;
							unique case (in_data.sub_mode)
								cles_pkg::MODE_BREATHE: begin
									if (step30) begin
										fade_q     <= fade_nx;
										going_up_q <= up_fade_nx;
										job_t_q    <= et;
										job_l_q    <= fade_nx;
									end
								end
								cles_pkg::MODE_BLINK: begin
									if (ph400_inc == cles_pkg::BLINK_ON) begin
										job_t_q <= et;
										job_l_q <= el;
									end else if (ph400_inc == cles_pkg::BLINK_OFF) begin
										warm_reg_q <= '0;
										cold_reg_q <= '0;
									end
								end
								cles_pkg::MODE_SWEEP: begin
									if (step30) begin
										going_up_q <= up_sweep_nx;
										job_t_q    <= sweep_nx;
										job_l_q    <= el;
									end
								end
								default: ;
							endcase
						end
					end
				end
				S_CLAMP: begin
					tc_q <= tc;
					if (job_set_q) begin
						saved_temp_q  <= tc;
						saved_light_q <= job_l_q;
					end
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (span_empty) begin
						warm_reg_q <= '0;
						cold_reg_q <= '0;
						state_q    <= S_OUT;
					end else begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					if (!warm_rsp.busy && !cold_rsp.busy) begin
						warm_reg_q <= warm_rsp.cmp;
						cold_reg_q <= cold_rsp.cmp;
						state_q    <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the output register frees
					if (out_free) begin
						out_data_q.warm_compare <= warm_reg_q;
						out_data_q.cold_compare <= cold_reg_q;
						out_data_q.changed      <= job_chg_q;
						state_q                 <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: design/cles_lane.sv
// One compare lane: bit-serial multiply by brightness, then bit-serial restoring division.
module cles_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  cles_pkg::lane_req_t req,
	output cles_pkg::lane_rsp_t rsp
);

	typedef enum logic [2:0] {
		L_IDLE = 3'b001,
		L_MUL  = 3'b010,
		L_DIV  = 3'b100
	} lane_state_t;

	lane_state_t                       state_q;
	logic [3:0]                        cnt_q;
	logic [cles_pkg::PROD_W-1:0]       mcand_q;
	logic [cles_pkg::LIGHT_W-1:0]      mplier_q;
	logic [cles_pkg::PROD_W-1:0]       acc_q;
	logic [cles_pkg::DEN_W-1:0]        den_q;
	logic [cles_pkg::DEN_W-1:0]        rem_q;
	logic [cles_pkg::QUO_W-1:0]        lo_q;
	logic [cles_pkg::QUO_W-1:0]        quo_q;
	logic [cles_pkg::CMP_W-1:0]        cmp_q;

	logic [cles_pkg::PROD_W-1:0]       acc_nx;
	logic [cles_pkg::DEN_W:0]          trial;
	logic                              qbit;
	logic [cles_pkg::DEN_W:0]          trial_sub;
	logic [cles_pkg::QUO_W-1:0]        quo_nx;

	assign acc_nx    = mplier_q[0] ? acc_q + mcand_q : acc_q;
	assign trial     = {rem_q, lo_q[cles_pkg::QUO_W-1]};
	assign qbit      = trial >= {1'b0, den_q};
	assign trial_sub = trial - {1'b0, den_q};
	assign quo_nx    = {quo_q[cles_pkg::QUO_W-2:0], qbit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= L_IDLE;
			cnt_q    <= '0;
			mcand_q  <= '0;
			mplier_q <= '0;
			acc_q    <= '0;
			den_q    <= '0;
			rem_q    <= '0;
			lo_q     <= '0;
			quo_q    <= '0;
			cmp_q    <= '0;
		end else begin
			unique case (state_q)
				L_IDLE: begin
					if (req.start) begin
						mcand_q  <= {7'd0, req.mcand};
						mplier_q <= req.light;
						acc_q    <= '0;
						den_q    <= req.den;
						cnt_q    <= '0;
						state_q  <= L_MUL;
					end
				end
				L_MUL: begin
					// add one brightness bit per cycle
					acc_q    <= acc_nx;
					mcand_q  <= {mcand_q[cles_pkg::PROD_W-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[cles_pkg::LIGHT_W-1:1]};
					cnt_q    <= cnt_q + 4'd1;
					if (cnt_q == 4'(cles_pkg::LIGHT_W - 1)) begin
						// quotient fits in QUO_W bits, so the upper part is already below den
						rem_q   <= {1'b0, acc_nx[cles_pkg::PROD_W-1:cles_pkg::QUO_W]};
						lo_q    <= acc_nx[cles_pkg::QUO_W-1:0];
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= L_DIV;
					end
				end
				L_DIV: begin
					rem_q <= qbit ? trial_sub[cles_pkg::DEN_W-1:0] : trial[cles_pkg::DEN_W-1:0];
					lo_q  <= {lo_q[cles_pkg::QUO_W-2:0], 1'b0};
					quo_q <= quo_nx;
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(cles_pkg::QUO_W - 1)) begin
						if (quo_nx > cles_pkg::CMP_MAX_Q) begin
							cmp_q <= cles_pkg::CMP_MAX;
						end else if (quo_nx < cles_pkg::CMP_MIN_Q) begin
							cmp_q <= '0;
						end else begin
							cmp_q <= quo_nx[cles_pkg::CMP_W-1:0];
						end
						state_q <= L_IDLE;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign rsp.busy = (state_q != L_IDLE);
	assign rsp.cmp  = cmp_q;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the CCT light effect sequencer: random and directed requests.
module tb;
	import cles_pkg::*;

	localparam int WRAP_TICKS   = 1200;
	localparam int STEP_PERIOD  = 30;
	localparam int BLINK_CYCLE  = 400;
	localparam int BLINK_LIT    = 200;
	localparam int SWEEP_K      = 50;
	localparam int WARM_K       = 530;
	localparam int COLD_K       = 1000;
	localparam int CMP_CAP      = 550;
	localparam int CMP_FLOOR    = 20;
	localparam int FULL_PCT     = 100;
	localparam int TEMP_TOP     = 16383;
	localparam int PHASE_ITEMS  = 125;
	localparam int SHOWN_ERRORS = 10;
	localparam int LIMIT_CYCLES = 1_000_000;

	class colour_scoreboard;
		logic [TEMP_W-1:0]  warm_t, cold_t;
		logic [CMP_W-1:0]   warm_r, cold_r;
		int                 ticks, fade;
		bit                 rising;
		logic [1:0]         prev_mode;
		logic [TEMP_W-1:0]  eff_temp, sweep_t, sav_temp;
		logic [LIGHT_W-1:0] eff_light, sav_light;
		out_item_t          due_results[$];
		int                 failures;

		function void clear();
			warm_t = TEMP_W'(2700);
			cold_t = TEMP_W'(6500);
			warm_r = '0;
			cold_r = '0;
			ticks = 0;
			fade = FULL_PCT;
			rising = 1'b0;
			prev_mode = MODE_NONE;
			eff_temp = '0;
			sweep_t = '0;
			sav_temp = '0;
			eff_light = '0;
			sav_light = LIGHT_W'(50);
			due_results.delete();
			failures = 0;
		endfunction

		function void write_reg(logic idx, logic [TEMP_W-1:0] v);
			if (idx == CFG_WARM) begin
				warm_t = v;
			end else begin
				cold_t = v;
			end
		endfunction

		function int due_count();
			return due_results.size();
		endfunction

		function logic [CMP_W-1:0] saturate(longint unsigned v);
			if (v > CMP_CAP) return CMP_W'(CMP_CAP);
			if (v < CMP_FLOOR) return '0;
			return CMP_W'(v);
		endfunction

		// Clamp, then load both compares; hand back the clamped temperature.
		function logic [TEMP_W-1:0] load_colour(logic [TEMP_W-1:0] t, logic [LIGHT_W-1:0] l);
			logic [TEMP_W-1:0] tc;
			longint unsigned den, wn, cn;
			tc = t;
			if (tc < warm_t) tc = warm_t;
			else if (tc > cold_t) tc = cold_t;
			if (tc > cold_t) tc = cold_t;
			if (cold_t <= warm_t) begin
				warm_r = '0;
				cold_r = '0;
			end else begin
				den = (cold_t - warm_t) * FULL_PCT;
				wn = (cold_t - tc) * WARM_K * l;
				cn = (tc - warm_t) * COLD_K * l;
				warm_r = saturate(wn / den);
				cold_r = saturate(cn / den);
			end
			return tc;
		endfunction

		function void note_request(in_item_t r);
			logic      changed;
			int        ph;
			int        s;
			out_item_t e;
			changed = 1'b0;
			if (r.cmd) begin
				sav_temp = load_colour(r.temperature, r.lightness);
				sav_light = r.lightness;
				changed = 1'b1;
			end else if (r.active) begin
				ticks = (ticks + 1) % WRAP_TICKS;
				if (prev_mode != r.sub_mode) begin
					prev_mode = r.sub_mode;
					eff_temp = sav_temp;
					sweep_t = sav_temp;
					eff_light = sav_light;
				end
				case (r.sub_mode)
					MODE_BREATHE: begin
						if (ticks % STEP_PERIOD == 0) begin
							if (!rising) begin
								if (fade <= 1) begin
									fade = 0;
									rising = 1'b1;
								end else begin
									fade--;
								end
							end else begin
								if (fade + 1 >= FULL_PCT) begin
									fade = FULL_PCT;
									rising = 1'b0;
								end else begin
									fade++;
								end
							end
							void'(load_colour(eff_temp, LIGHT_W'(fade)));
							changed = 1'b1;
						end
					end
					MODE_BLINK: begin
						ph = ticks % BLINK_CYCLE;
						if (ph == BLINK_LIT) begin
							void'(load_colour(eff_temp, eff_light));
							changed = 1'b1;
						end else if (ph == 0) begin
							warm_r = '0;
							cold_r = '0;
							changed = 1'b1;
						end
					end
					MODE_SWEEP: begin
						if (ticks % STEP_PERIOD == 0) begin
							s = int'(sweep_t);
							if (!rising) begin
								s -= SWEEP_K;
								if (s <= int'(warm_t)) begin
									rising = 1'b1;
									s = int'(warm_t);
								end
							end else begin
								s += SWEEP_K;
								if (s >= int'(cold_t)) begin
									rising = 1'b0;
									s = int'(cold_t);
								end
							end
							sweep_t = TEMP_W'(s);
							void'(load_colour(sweep_t, eff_light));
							changed = 1'b1;
						end
					end
					default: ;
				endcase
			end
			e.warm_compare = warm_r;
			e.cold_compare = cold_r;
			e.changed = changed;
			due_results.push_back(e);
		endfunction

		function void report(string what, out_item_t e, out_item_t a);
			failures++;
			if (failures <= SHOWN_ERRORS) begin
				$display("tb: %s: expected warm %0d cold %0d changed %0d, got warm %0d cold %0d changed %0d",
					what, e.warm_compare, e.cold_compare, e.changed,
					a.warm_compare, a.cold_compare, a.changed);
			end
		endfunction

		function void check_result(out_item_t a);
			out_item_t e;
			if (due_results.size() == 0) begin
				report("result with no request outstanding", '0, a);
				return;
			end
			e = due_results.pop_front();
			if (a.warm_compare !== e.warm_compare || a.cold_compare !== e.cold_compare ||
					a.changed !== e.changed) begin
				report("compare mismatch", e, a);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_stall;
	out_item_t          out_data;
	logic               cfg_we;
	logic               cfg_index;
	logic [TEMP_W-1:0]  cfg_data;
	int                 snd_idle;
	int                 rcv_idle;
	int                 cycles = 0;
	colour_scoreboard   sb;

	cct_light_effect_sequencer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rcv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	function automatic in_item_t tick_request(bit act, logic [1:0] mode);
		in_item_t r;
		r.cmd = 1'b0;
		r.active = act;
		r.sub_mode = mode;
		r.temperature = TEMP_W'($urandom_range(TEMP_TOP));
		r.lightness = LIGHT_W'($urandom_range(127));
		return r;
	endfunction

	function automatic in_item_t colour_fixed(int t, int l);
		in_item_t r;
		r.cmd = 1'b1;
		r.active = 1'($urandom_range(1));
		r.sub_mode = 2'($urandom_range(3));
		r.temperature = TEMP_W'(t);
		r.lightness = LIGHT_W'(l);
		return r;
	endfunction

	// Aim the temperature near the clamp bounds half of the time.
	function automatic in_item_t colour_request();
		int t;
		int l;
		int pick;
		case ($urandom_range(3))
			0: t = $urandom_range(TEMP_TOP);
			1: t = int'(sb.warm_t) + int'($urandom_range(120)) - 60;
			2: t = int'(sb.cold_t) + int'($urandom_range(120)) - 60;
			default: t = $urandom_range(int'(sb.warm_t), int'(sb.cold_t));
		endcase
		if (t < 0) t = 0;
		if (t > TEMP_TOP) t = TEMP_TOP;
		pick = $urandom_range(9);
		if (pick < 6) l = $urandom_range(FULL_PCT);
		else if (pick < 8) l = $urandom_range(FULL_PCT + 1, 127);
		else if (pick == 8) l = 0;
		else l = FULL_PCT;
		return colour_fixed(t, l);
	endfunction

	// Hold the request until it is taken, then note it for prediction.
	task automatic send_request(in_item_t r);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(r);
	endtask

	task automatic send_ticks(int n, bit act, logic [1:0] mode);
		repeat (n) send_request(tick_request(act, mode));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.due_count() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [TEMP_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	function automatic logic [1:0] pick_mode();
		int p;
		p = $urandom_range(99);
		if (p < 35) return MODE_BLINK;
		if (p < 60) return MODE_SWEEP;
		if (p < 85) return MODE_BREATHE;
		return MODE_NONE;
	endfunction

	task automatic random_runs(int n);
		int         done;
		int         kind;
		int         len;
		logic [1:0] mode;
		in_item_t   r;
		done = 0;
		while (done < n) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				mode = pick_mode();
				len = $urandom_range(20, 240);
				if ($urandom_range(1)) begin
					send_request(colour_request());
					done++;
				end
				repeat (len) begin
					kind = $urandom_range(99);
					if (kind < 3) r = colour_request();
					else if (kind < 5) r = tick_request(1'b0, mode);
					else r = tick_request(1'b1, mode);
					send_request(r);
					if (r.cmd || r.active) done++;
				end
			end else if (kind < 85) begin
				repeat ($urandom_range(1, 4)) begin
					send_request(colour_request());
					done++;
				end
			end else begin
				// noise: scattered ticks with any mode and either activity
				repeat ($urandom_range(1, 10)) begin
					r = tick_request(1'($urandom_range(1)), 2'($urandom_range(3)));
					send_request(r);
					if (r.active) done++;
				end
			end
		end
	endtask

	initial begin
		int warm_set [5];
		int cold_set [5];
		warm_set = '{1000, 1000, TEMP_TOP, 5000, 0};
		cold_set = '{TEMP_TOP, 1001, 1000, 5000, 0};
		sb = new();
		sb.clear();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_WARM;
		cfg_data <= '0;
		snd_idle = 34;
		rcv_idle = 65;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every mode, inactive tick, set colour after an inactive tick
		send_request(tick_request(1'b0, MODE_NONE));
		send_request(colour_fixed(0, 0));
		send_request(colour_fixed(TEMP_TOP, 127));
		send_request(colour_fixed(2700, FULL_PCT));
		send_request(colour_fixed(6500, FULL_PCT));
		send_request(colour_fixed(4600, FULL_PCT + 1));
		send_request(tick_request(1'b1, MODE_NONE));
		send_request(tick_request(1'b1, MODE_BREATHE));
		send_request(tick_request(1'b1, MODE_BLINK));
		send_request(tick_request(1'b1, MODE_SWEEP));
		send_request(tick_request(1'b0, MODE_SWEEP));
		send_request(colour_fixed(2700, 80));
		send_request(tick_request(1'b1, MODE_NONE));

		// sweep hits the warm bound and turns up, breathing then turns at full
		send_ticks(STEP_PERIOD, 1'b1, MODE_SWEEP);
		send_ticks(3 * STEP_PERIOD, 1'b1, MODE_BREATHE);
		send_ticks(BLINK_CYCLE, 1'b1, MODE_BLINK);
		random_runs(PHASE_ITEMS);

		for (int p = 0; p < 5; p++) begin
			drain();
			if (p == 1) begin
				snd_idle = 65;
				rcv_idle = 34;
			end else if (p == 3) begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			if (p == 4) begin
				warm_set[p] = $urandom_range(1000, 9000);
				cold_set[p] = warm_set[p] + $urandom_range(1, TEMP_TOP - warm_set[p]);
			end
			write_reg(CFG_WARM, TEMP_W'(warm_set[p]));
			write_reg(CFG_COLD, TEMP_W'(cold_set[p]));
			random_runs(PHASE_ITEMS);
		end

		drain();
		repeat (30) @(posedge clk);
		if (sb.failures == 0 && sb.due_count() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
